// ===== design/mlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared types, codes and the sigmoid table builder for the perceptron core.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int OP_W       = 2;
    localparam int ADDR_W     = 8;
    localparam int ACT_W      = 2;
    localparam int BIAS_EN_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int LAYER_W    = 2;

    localparam int SIG_DEPTH  = 1024;
    localparam int SIG_IW     = 10;
    localparam int SIG_HALF   = 512;
    localparam longint unsigned SIG_ONE  = 64'd4096;
    localparam longint unsigned EXP_STEP = 64'd4227950503;

    localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_INFER        = 2'd2;

    localparam logic [ACT_W-1:0] ACT_IDENTITY = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SIGMOID  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELU     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_ONE_ACT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_TWO_ACT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ACT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_ENABLE    = 2'd3;

    localparam logic [LAYER_W-1:0] LAYER_ONE = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_TWO = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_OUT = 2'd2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef data_t sig_rom_t [SIG_DEPTH];

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic bias_en;
    } mac_ctrl_t;

    // Shift-subtract quotient, valid while the quotient stays below 2^16.
    function automatic longint unsigned sig_div(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int b;
        quo = '0;
        rem = num;
        for (b = 15; b >= 0; b--)
        begin
            if (rem >= (den << b))
            begin
                rem = rem - (den << b);
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    function automatic sig_rom_t sig_build();
        sig_rom_t rom;
        longint unsigned e;
        longint unsigned d;
        longint unsigned y;
        int m;
        rom = '{default: '0};
        e = 64'd1 << 32;
        for (m = 0; m <= SIG_HALF; m++)
        begin
            if (m > 0)
            begin
                e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
            end
            d = (64'd1 << 32) + e;
            y = sig_div((64'd1 << 44) + (d >> 1), d);
            if (m < SIG_HALF)
            begin
                rom[SIG_HALF + m] = DATA_W'(y);
            end
            if (m > 0)
            begin
                rom[SIG_HALF - m] = DATA_W'(SIG_ONE - y);
            end
        end
        return rom;
    endfunction

endpackage

// ===== design/mlp_forward_inference_core.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_inference_core
// Dense perceptron inference in Q4.12 over one shared multiply-accumulate unit.
// Weight and bias writes are accepted while idle; an inference issues each neuron's
// fan-in through the MAC and waits for its activation before the next neuron.
// The single MAC allows one inference at a time; a held result stalls inferences.
// Reset clears control registers, sets every activation to sigmoid and enables all biases; the stores stay undefined.
// ----------------------------------------------------------------------------
module mlp_forward_inference_core #(
    parameter int INPUT_COUNT     = 2,
    parameter int HIDDEN_ONE_SIZE = 10,
    parameter int HIDDEN_TWO_SIZE = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address, coefficient, first_input, second_input
    input  logic [55:0]                       s_axis_tdata,
    // operation
    input  logic [mlp_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // output_net, output_value
    output logic [31:0]                       m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mlp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WEIGHT_DEPTH = INPUT_COUNT * HIDDEN_ONE_SIZE
                                + HIDDEN_ONE_SIZE * HIDDEN_TWO_SIZE + HIDDEN_TWO_SIZE;
    localparam int BIAS_DEPTH   = HIDDEN_ONE_SIZE + HIDDEN_TWO_SIZE + 1;
    localparam int W_AW         = $clog2(WEIGHT_DEPTH);
    localparam int B_AW         = $clog2(BIAS_DEPTH);
    localparam int FAN_A        = (INPUT_COUNT > HIDDEN_ONE_SIZE) ? INPUT_COUNT
                                                                  : HIDDEN_ONE_SIZE;
    localparam int MAX_FAN      = (FAN_A > HIDDEN_TWO_SIZE) ? FAN_A : HIDDEN_TWO_SIZE;
    localparam int JW           = (MAX_FAN > 1) ? $clog2(MAX_FAN) : 1;
    localparam int MAX_N        = (HIDDEN_ONE_SIZE > HIDDEN_TWO_SIZE) ? HIDDEN_ONE_SIZE
                                                                      : HIDDEN_TWO_SIZE;
    localparam int KW           = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int H1_IW        = (HIDDEN_ONE_SIZE > 1) ? $clog2(HIDDEN_ONE_SIZE) : 1;
    localparam int H2_IW        = (HIDDEN_TWO_SIZE > 1) ? $clog2(HIDDEN_TWO_SIZE) : 1;

    localparam logic [JW-1:0] FAN1_LAST = JW'(INPUT_COUNT - 1);
    localparam logic [JW-1:0] FAN2_LAST = JW'(HIDDEN_ONE_SIZE - 1);
    localparam logic [JW-1:0] FAN3_LAST = JW'(HIDDEN_TWO_SIZE - 1);
    localparam logic [KW-1:0] N1_LAST   = KW'(HIDDEN_ONE_SIZE - 1);
    localparam logic [KW-1:0] N2_LAST   = KW'(HIDDEN_TWO_SIZE - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [mlp_pkg::LAYER_W-1:0]    layer_reg, layer_next;
    logic [JW-1:0]                  j_reg, j_next;
    logic [KW-1:0]                  k_reg, k_next;
    logic [W_AW-1:0]                waddr_reg, waddr_next;
    logic [B_AW-1:0]                baddr_reg, baddr_next;
    logic [mlp_pkg::ACT_W-1:0]      h1_act_reg, h2_act_reg, out_act_reg;
    logic [mlp_pkg::BIAS_EN_W-1:0]  bias_en_reg;
    mlp_pkg::data_t                 x0_reg, x1_reg;
    mlp_pkg::data_t                 hid1_reg [HIDDEN_ONE_SIZE];
    mlp_pkg::data_t                 hid2_reg [HIDDEN_TWO_SIZE];
    logic                           s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [JW-1:0]                  s1_j_reg;
    logic                           out_valid_reg;
    mlp_pkg::data_t                 out_net_reg, out_value_reg;

    logic                           in_xfer, cfg_xfer, issue;
    logic [mlp_pkg::OP_W-1:0]       op;
    logic [mlp_pkg::ADDR_W-1:0]     addr;
    mlp_pkg::data_t                 coef, in0, in1;
    logic [JW-1:0]                  fan_last;
    logic [mlp_pkg::ACT_W-1:0]      act_code;
    logic                           layer_bias_en;
    mlp_pkg::data_t                 operand;
    mlp_pkg::data_t                 rd_weight, rd_bias;
    mlp_pkg::mac_ctrl_t             mac_ctrl;
    logic                           net_valid;
    mlp_pkg::data_t                 net;
    logic                           act_valid;
    mlp_pkg::data_t                 act_net, act_value;

    assign op   = s_axis_tuser;
    assign addr = s_axis_tdata[7:0];
    assign coef = s_axis_tdata[23:8];
    assign in0  = s_axis_tdata[39:24];
    assign in1  = s_axis_tdata[55:40];

    assign s_axis_tready = (state_reg == ST_IDLE)
                         && ((op != mlp_pkg::OP_INFER) || !out_valid_reg || m_axis_tready);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign issue    = (state_reg == ST_ISSUE);

    always_comb
    begin
        unique case (layer_reg)
            mlp_pkg::LAYER_ONE:
            begin
                fan_last      = FAN1_LAST;
                act_code      = h1_act_reg;
                layer_bias_en = bias_en_reg[0];
                operand       = (s1_j_reg == '0) ? x0_reg : x1_reg;
            end
            mlp_pkg::LAYER_TWO:
            begin
                fan_last      = FAN2_LAST;
                act_code      = h2_act_reg;
                layer_bias_en = bias_en_reg[1];
                operand       = hid1_reg[s1_j_reg[H1_IW-1:0]];
            end
            default:
            begin
                fan_last      = FAN3_LAST;
                act_code      = out_act_reg;
                layer_bias_en = bias_en_reg[2];
                operand       = hid2_reg[s1_j_reg[H2_IW-1:0]];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        waddr_next = waddr_reg;
        baddr_next = baddr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (op == mlp_pkg::OP_INFER))
                begin
                    state_next = ST_ISSUE;
                    layer_next = mlp_pkg::LAYER_ONE;
                    j_next     = '0;
                    k_next     = '0;
                    waddr_next = '0;
                    baddr_next = '0;
                end
            end
            ST_ISSUE:
            begin
                waddr_next = waddr_reg + 1'b1;
                if (j_reg == fan_last)
                begin
                    j_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (act_valid)
                begin
                    baddr_next = baddr_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ISSUE;
                    unique case (layer_reg)
                        mlp_pkg::LAYER_ONE:
                        begin
                            if (k_reg == N1_LAST)
                            begin
                                layer_next = mlp_pkg::LAYER_TWO;
                                k_next     = '0;
                            end
                        end
                        mlp_pkg::LAYER_TWO:
                        begin
                            if (k_reg == N2_LAST)
                            begin
                                layer_next = mlp_pkg::LAYER_OUT;
                                k_next     = '0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            layer_reg    <= mlp_pkg::LAYER_ONE;
            j_reg        <= '0;
            k_reg        <= '0;
            waddr_reg    <= '0;
            baddr_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            layer_reg    <= layer_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            waddr_reg    <= waddr_next;
            baddr_reg    <= baddr_next;
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_act_reg  <= mlp_pkg::ACT_SIGMOID;
            h2_act_reg  <= mlp_pkg::ACT_SIGMOID;
            out_act_reg <= mlp_pkg::ACT_SIGMOID;
            bias_en_reg <= '1;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg_index)
                mlp_pkg::CFG_HIDDEN_ONE_ACT: h1_act_reg  <= cfg_data[mlp_pkg::ACT_W-1:0];
                mlp_pkg::CFG_HIDDEN_TWO_ACT: h2_act_reg  <= cfg_data[mlp_pkg::ACT_W-1:0];
                mlp_pkg::CFG_OUTPUT_ACT:     out_act_reg <= cfg_data[mlp_pkg::ACT_W-1:0];
                mlp_pkg::CFG_BIAS_ENABLE:    bias_en_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act_valid && (state_reg == ST_WAIT) && (layer_reg == mlp_pkg::LAYER_OUT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (op == mlp_pkg::OP_INFER))
        begin
            x0_reg <= in0;
            x1_reg <= in1;
        end
        s1_first_reg <= (j_reg == '0);
        s1_last_reg  <= (j_reg == fan_last);
        s1_j_reg     <= j_reg;
        if (act_valid && (state_reg == ST_WAIT))
        begin
            unique case (layer_reg)
                mlp_pkg::LAYER_ONE: hid1_reg[k_reg[H1_IW-1:0]] <= act_value;
                mlp_pkg::LAYER_TWO: hid2_reg[k_reg[H2_IW-1:0]] <= act_value;
                default:
                begin
                    out_net_reg   <= act_net;
                    out_value_reg <= act_value;
                end
            endcase
        end
    end

    assign mac_ctrl.valid   = s1_valid_reg;
    assign mac_ctrl.first   = s1_first_reg;
    assign mac_ctrl.last    = s1_last_reg;
    assign mac_ctrl.bias_en = layer_bias_en;

    mlp_coef_store #(
        .WEIGHT_DEPTH (WEIGHT_DEPTH),
        .BIAS_DEPTH   (BIAS_DEPTH),
        .W_AW         (W_AW),
        .B_AW         (B_AW)
    ) u_store (
        .clk          (clk),
        .wr_weight_en (in_xfer && (op == mlp_pkg::OP_WRITE_WEIGHT)),
        .wr_bias_en   (in_xfer && (op == mlp_pkg::OP_WRITE_BIAS)),
        .wr_addr      (addr),
        .wr_data      (coef),
        .rd_en        (issue),
        .rd_waddr     (waddr_reg),
        .rd_baddr     (baddr_reg),
        .rd_weight    (rd_weight),
        .rd_bias      (rd_bias)
    );

    mlp_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .weight    (rd_weight),
        .operand   (operand),
        .bias      (rd_bias),
        .net_valid (net_valid),
        .net       (net)
    );

    mlp_act u_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (net_valid),
        .in_net    (net),
        .code      (act_code),
        .out_valid (act_valid),
        .out_net   (act_net),
        .out_value (act_value)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_value_reg, out_net_reg};

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_act_wait: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid |-> (state_reg == ST_WAIT))
        else $error("activation result while not waiting");

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WAIT)
                              && ($past(layer_reg) == mlp_pkg::LAYER_OUT))
        else $error("result raised outside output neuron");

    a_issue_addr: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (32'(waddr_reg) < WEIGHT_DEPTH))
        else $error("weight read beyond store");
`endif

endmodule

// ===== design/mlp_coef_store.sv =====
// ----------------------------------------------------------------------------
// mlp_coef_store
// Weight and bias memories: one write port and one registered read port each.
// ----------------------------------------------------------------------------
module mlp_coef_store #(
    parameter int WEIGHT_DEPTH = 130,
    parameter int BIAS_DEPTH   = 21,
    parameter int W_AW         = 8,
    parameter int B_AW         = 5
) (
    input  logic                             clk,
    input  logic                             wr_weight_en,
    input  logic                             wr_bias_en,
    input  logic [mlp_pkg::ADDR_W-1:0]       wr_addr,
    input  mlp_pkg::data_t                   wr_data,
    input  logic                             rd_en,
    input  logic [W_AW-1:0]                  rd_waddr,
    input  logic [B_AW-1:0]                  rd_baddr,
    output mlp_pkg::data_t                   rd_weight,
    output mlp_pkg::data_t                   rd_bias
);

    mlp_pkg::data_t weight_mem [WEIGHT_DEPTH];
    mlp_pkg::data_t bias_mem [BIAS_DEPTH];
    mlp_pkg::data_t weight_rd_reg;
    mlp_pkg::data_t bias_rd_reg;

    logic [mlp_pkg::ADDR_W+W_AW-1:0] waddr_wide;
    logic [mlp_pkg::ADDR_W+B_AW-1:0] baddr_wide;
    logic                            weight_hit;
    logic                            bias_hit;

    assign waddr_wide = {{W_AW{1'b0}}, wr_addr};
    assign baddr_wide = {{B_AW{1'b0}}, wr_addr};
    assign weight_hit = 32'(waddr_wide) < WEIGHT_DEPTH;
    assign bias_hit   = 32'(baddr_wide) < BIAS_DEPTH;

    always_ff @(posedge clk)
    begin
        if (wr_weight_en && weight_hit)
        begin
            weight_mem[waddr_wide[W_AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            weight_rd_reg <= weight_mem[rd_waddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_bias_en && bias_hit)
        begin
            bias_mem[baddr_wide[B_AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            bias_rd_reg <= bias_mem[rd_baddr];
        end
    end

    assign rd_weight = weight_rd_reg;
    assign rd_bias   = bias_rd_reg;

endmodule

// ===== design/mlp_mac.sv =====
// ----------------------------------------------------------------------------
// mlp_mac
// Shared multiply-accumulate unit with bias preload, floor shift and
// 16-bit saturation of the neuron net value.
// ----------------------------------------------------------------------------
module mlp_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  mlp_pkg::mac_ctrl_t ctrl,
    input  mlp_pkg::data_t     weight,
    input  mlp_pkg::data_t     operand,
    input  mlp_pkg::data_t     bias,
    output logic               net_valid,
    output mlp_pkg::data_t     net
);

    localparam int SH_W = mlp_pkg::ACC_W - mlp_pkg::FRAC_W;
    localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] SAT_MIN = -SH_W'(32768);

    logic signed [mlp_pkg::PROD_W-1:0] prod_reg;
    logic signed [mlp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mlp_pkg::ACC_W-1:0]  bias_term;
    logic signed [SH_W-1:0]            shifted;
    logic                              pv_reg;
    logic                              plast_reg;
    logic                              fin_reg;
    logic                              net_valid_reg;
    mlp_pkg::data_t                    net_reg;
    mlp_pkg::data_t                    net_next;

    assign bias_term = {{(mlp_pkg::ACC_W - mlp_pkg::DATA_W - mlp_pkg::FRAC_W)
                        {bias[mlp_pkg::DATA_W-1]}}, bias, {mlp_pkg::FRAC_W{1'b0}}};
    assign shifted   = SH_W'(acc_reg >>> mlp_pkg::FRAC_W);

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            net_next = 16'sd32767;
        end
        else if (shifted < SAT_MIN)
        begin
            net_next = -16'sd32768;
        end
        else
        begin
            net_next = shifted[mlp_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= 1'b0;
            plast_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            net_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg        <= ctrl.valid;
            plast_reg     <= ctrl.last;
            fin_reg       <= pv_reg && plast_reg;
            net_valid_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * operand;
        priority if (ctrl.valid && ctrl.first)
        begin
            acc_reg <= ctrl.bias_en ? bias_term : '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + mlp_pkg::ACC_W'(prod_reg);
        end
        if (fin_reg)
        begin
            net_reg <= net_next;
        end
    end

    assign net_valid = net_valid_reg;
    assign net       = net_reg;

endmodule

// ===== design/mlp_act.sv =====
// ----------------------------------------------------------------------------
// mlp_act
// Activation stage: registered sigmoid table read, ReLU and identity select.
// ----------------------------------------------------------------------------
module mlp_act (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  mlp_pkg::data_t             in_net,
    input  logic [mlp_pkg::ACT_W-1:0]  code,
    output logic                       out_valid,
    output mlp_pkg::data_t             out_net,
    output mlp_pkg::data_t             out_value
);

    localparam mlp_pkg::sig_rom_t SIG_ROM = mlp_pkg::sig_build();

    logic [mlp_pkg::SIG_IW-1:0]  sig_idx;
    mlp_pkg::data_t              sig_reg;
    mlp_pkg::data_t              net_reg;
    logic [mlp_pkg::ACT_W-1:0]   code_reg;
    logic                        valid_reg;

    assign sig_idx = {~in_net[mlp_pkg::DATA_W-1],
                      in_net[mlp_pkg::DATA_W-2:mlp_pkg::DATA_W-mlp_pkg::SIG_IW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg  <= SIG_ROM[sig_idx];
        net_reg  <= in_net;
        code_reg <= code;
    end

    always_comb
    begin
        unique case (code_reg)
            mlp_pkg::ACT_SIGMOID:
            begin
                out_value = sig_reg;
            end
            mlp_pkg::ACT_RELU:
            begin
                out_value = (net_reg > 16'sd0) ? net_reg : 16'sd0;
            end
            default:
            begin
                out_value = net_reg;
            end
        endcase
    end

    assign out_valid = valid_reg;
    assign out_net   = net_reg;

endmodule

// ===== verif/mlp_forward_inference_core_tb.sv =====
// ----------------------------------------------------------------------------
// mlp_forward_inference_core_tb
// Self-checking bench for the 2-10-10-1 Q4.12 perceptron core. Loads every
// weight and bias, then runs directed edge values, each activation and bias
// setting, and random write/infer traffic with random stalls on both streams.
// A model in the bench predicts output_net and output_value per inference and
// every result transfer is compared in order against it.
// ----------------------------------------------------------------------------
module mlp_forward_inference_core_tb;

    typedef mlp_pkg::data_t data_t;

    localparam int IN_COUNT     = 2;
    localparam int H1_COUNT     = 10;
    localparam int H2_COUNT     = 10;
    localparam int L2_BASE      = IN_COUNT * H1_COUNT;
    localparam int OUT_BASE     = L2_BASE + H1_COUNT * H2_COUNT;
    localparam int WEIGHT_COUNT = OUT_BASE + H2_COUNT;
    localparam int BIAS_COUNT   = H1_COUNT + H2_COUNT + 1;
    localparam int OUT_BIAS     = H1_COUNT + H2_COUNT;

    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PRINT_LIMIT   = 20;

    localparam logic [mlp_pkg::OP_W-1:0]  OP_RESERVED = 2'd3;
    localparam logic [mlp_pkg::ACT_W-1:0] ACT_SPARE   = 2'd3;
    localparam longint unsigned DECAY_Q32    = 64'd4227950503;

    typedef struct {
        data_t net;
        data_t value;
    } net_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [55:0]                    s_axis_tdata;
    logic [mlp_pkg::OP_W-1:0]       s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mlp_pkg::CFG_DATA_W-1:0] cfg_data;

    data_t       weight_mem [WEIGHT_COUNT];
    data_t       bias_mem [BIAS_COUNT];
    data_t       sig_lut [mlp_pkg::SIG_DEPTH];
    logic [1:0]  act_h1  = mlp_pkg::ACT_SIGMOID;
    logic [1:0]  act_h2  = mlp_pkg::ACT_SIGMOID;
    logic [1:0]  act_out = mlp_pkg::ACT_SIGMOID;
    logic [2:0]  bias_on = 3'b111;

    net_result_t pending_outputs [$];

    int idle_pct = 20;
    int stall_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int infer_count = 0;
    int store_write_count = 0;
    int stray_write_count = 0;
    int reserved_count = 0;
    int reg_write_count = 0;
    int setting_count = 0;

    mlp_forward_inference_core #(
        .INPUT_COUNT    (IN_COUNT),
        .HIDDEN_ONE_SIZE(H1_COUNT),
        .HIDDEN_TWO_SIZE(H2_COUNT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin : sigmoid_lut_build
        longint unsigned decay;
        longint unsigned denom;
        longint unsigned level;
        int m;
        decay = 64'd1 << 32;
        for (m = 0; m <= mlp_pkg::SIG_HALF; m++)
        begin
            if (m > 0)
            begin
                decay = (decay * DECAY_Q32 + (64'd1 << 31)) >> 32;
            end
            denom = (64'd1 << 32) + decay;
            level = ((64'd1 << 44) + denom / 2) / denom;
            if (m < mlp_pkg::SIG_HALF)
            begin
                sig_lut[mlp_pkg::SIG_HALF + m] = data_t'(level);
            end
            if (m > 0)
            begin
                sig_lut[mlp_pkg::SIG_HALF - m] = data_t'(64'd4096 - level);
            end
        end
    end

    function automatic data_t saturate_net(longint acc);
        longint q;
        q = acc >>> mlp_pkg::FRAC_W;
        if (q > 32767)
        begin
            return 16'sh7fff;
        end
        if (q < -32768)
        begin
            return 16'sh8000;
        end
        return data_t'(q);
    endfunction

    function automatic data_t activate(logic [1:0] code, data_t net);
        case (code)
            mlp_pkg::ACT_SIGMOID: return sig_lut[(int'(net) >>> 6) + mlp_pkg::SIG_HALF];
            mlp_pkg::ACT_RELU:    return (net > 0) ? net : data_t'(0);
            default:              return net;
        endcase
    endfunction

    function automatic net_result_t predict_outputs(data_t in0, data_t in1);
        data_t       h1 [H1_COUNT];
        data_t       h2 [H2_COUNT];
        longint      acc;
        net_result_t r;
        int          k;
        int          j;
        for (k = 0; k < H1_COUNT; k++)
        begin
            acc = bias_on[0] ? longint'(bias_mem[k]) * 4096 : 0;
            acc += longint'(weight_mem[k * IN_COUNT]) * longint'(in0);
            acc += longint'(weight_mem[k * IN_COUNT + 1]) * longint'(in1);
            h1[k] = activate(act_h1, saturate_net(acc));
        end
        for (k = 0; k < H2_COUNT; k++)
        begin
            acc = bias_on[1] ? longint'(bias_mem[H1_COUNT + k]) * 4096 : 0;
            for (j = 0; j < H1_COUNT; j++)
            begin
                acc += longint'(weight_mem[L2_BASE + k * H1_COUNT + j]) * longint'(h1[j]);
            end
            h2[k] = activate(act_h2, saturate_net(acc));
        end
        acc = bias_on[2] ? longint'(bias_mem[OUT_BIAS]) * 4096 : 0;
        for (j = 0; j < H2_COUNT; j++)
        begin
            acc += longint'(weight_mem[OUT_BASE + j]) * longint'(h2[j]);
        end
        r.net   = saturate_net(acc);
        r.value = activate(act_out, r.net);
        return r;
    endfunction

    // Check results, track register and store writes, predict on each accepted inference.
    always @(posedge clk)
    begin : result_monitor
        net_result_t want;
        logic [7:0]  addr;
        data_t       coef;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= PRINT_LIMIT)
                begin
                    $display("%0t: unexpected result transfer, actual net %0d value %0d",
                             $time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
                end
            end
            else
            begin
                want = pending_outputs.pop_front();
                if (m_axis_tdata[15:0] !== want.net)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                    begin
                        $display("%0t: output_net mismatch, expected %0d, actual %0d",
                                 $time, want.net, $signed(m_axis_tdata[15:0]));
                    end
                end
                if (m_axis_tdata[31:16] !== want.value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= PRINT_LIMIT)
                    begin
                        $display("%0t: output_value mismatch, expected %0d, actual %0d",
                                 $time, want.value, $signed(m_axis_tdata[31:16]));
                    end
                end
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_write_count++;
            case (cfg_index)
                mlp_pkg::CFG_HIDDEN_ONE_ACT: act_h1  = cfg_data[1:0];
                mlp_pkg::CFG_HIDDEN_TWO_ACT: act_h2  = cfg_data[1:0];
                mlp_pkg::CFG_OUTPUT_ACT:     act_out = cfg_data[1:0];
                mlp_pkg::CFG_BIAS_ENABLE:    bias_on = cfg_data;
                default: ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            addr = s_axis_tdata[7:0];
            coef = s_axis_tdata[23:8];
            case (s_axis_tuser)
                mlp_pkg::OP_WRITE_WEIGHT:
                begin
                    if (addr < WEIGHT_COUNT)
                    begin
                        weight_mem[addr] = coef;
                        store_write_count++;
                    end
                    else
                    begin
                        stray_write_count++;
                    end
                end
                mlp_pkg::OP_WRITE_BIAS:
                begin
                    if (addr < BIAS_COUNT)
                    begin
                        bias_mem[addr] = coef;
                        store_write_count++;
                    end
                    else
                    begin
                        stray_write_count++;
                    end
                end
                mlp_pkg::OP_INFER:
                begin
                    pending_outputs.insert(pending_outputs.size(),
                                           predict_outputs(s_axis_tdata[39:24],
                                                           s_axis_tdata[55:40]));
                    infer_count++;
                end
                default: reserved_count++;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_pct != 0 && $urandom_range(0, 199) < idle_pct)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_outputs.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic data_t rand_sample();
        case ($urandom_range(0, 3))
            0:       return data_t'($urandom);
            3:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return data_t'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic send_item(input logic [mlp_pkg::OP_W-1:0] op, input logic [7:0] addr,
                             input data_t coef, input data_t x0, input data_t x1);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {x1, x0, coef, addr};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mlp_pkg::CFG_IDX_W-1:0] idx, input logic [2:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [2:0] h1, input logic [2:0] h2,
                                  input logic [2:0] out, input logic [2:0] be);
        drain_results();
        write_reg(mlp_pkg::CFG_HIDDEN_ONE_ACT, h1);
        write_reg(mlp_pkg::CFG_HIDDEN_TWO_ACT, h2);
        write_reg(mlp_pkg::CFG_OUTPUT_ACT, out);
        write_reg(mlp_pkg::CFG_BIAS_ENABLE, be);
        setting_count++;
    endtask

    task automatic drive_traffic(input int count, input int infer_pct);
        int n;
        int pick;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < infer_pct)
            begin
                send_item(mlp_pkg::OP_INFER, 8'($urandom), data_t'($urandom),
                          rand_sample(), rand_sample());
            end
            else if (pick < infer_pct + (100 - infer_pct) / 2)
            begin
                send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'($urandom_range(0, WEIGHT_COUNT - 1)),
                          rand_sample(), data_t'($urandom), data_t'($urandom));
            end
            else if (pick < 88)
            begin
                send_item(mlp_pkg::OP_WRITE_BIAS, 8'($urandom_range(0, BIAS_COUNT - 1)),
                          rand_sample(), data_t'($urandom), data_t'($urandom));
            end
            else if (pick < 92)
            begin
                send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'($urandom_range(WEIGHT_COUNT, 255)),
                          data_t'($urandom), data_t'($urandom), data_t'($urandom));
            end
            else if (pick < 96)
            begin
                send_item(mlp_pkg::OP_WRITE_BIAS, 8'($urandom_range(BIAS_COUNT, 255)),
                          data_t'($urandom), data_t'($urandom), data_t'($urandom));
            end
            else
            begin
                send_item(OP_RESERVED, 8'($urandom), data_t'($urandom),
                          data_t'($urandom), data_t'($urandom));
            end
        end
    endtask

    // Fill both stores before the first inference; run at reset settings.
    task automatic test_reset_defaults();
        int a;
        for (a = 0; a < WEIGHT_COUNT; a++)
        begin
            send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'(a),
                      data_t'(int'($urandom_range(0, 4096)) - 2048),
                      data_t'($urandom), data_t'($urandom));
        end
        for (a = 0; a < BIAS_COUNT; a++)
        begin
            send_item(mlp_pkg::OP_WRITE_BIAS, 8'(a),
                      data_t'(int'($urandom_range(0, 4096)) - 2048),
                      data_t'($urandom), data_t'($urandom));
        end
        drive_traffic(6, 100);
    endtask

    task automatic test_edge_values();
        send_item(mlp_pkg::OP_INFER, 8'h00, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_INFER, 8'hff, 16'shffff, 16'sh7fff, 16'sh7fff);
        send_item(mlp_pkg::OP_INFER, 8'h00, 16'sh0000, 16'sh8000, 16'sh8000);
        send_item(mlp_pkg::OP_INFER, 8'h55, 16'sh5555, 16'sh7fff, 16'sh8000);
        send_item(mlp_pkg::OP_INFER, 8'haa, 16'shaaaa, 16'sh8000, 16'sh7fff);
        send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'd0, 16'sh7fff, 16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'd1, 16'sh8000, 16'shffff, 16'shffff);
        send_item(mlp_pkg::OP_WRITE_BIAS, 8'd0, 16'sh7fff, 16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'(WEIGHT_COUNT - 1), 16'sh8000,
                  16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_BIAS, 8'(BIAS_COUNT - 1), 16'sh8000,
                  16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'(WEIGHT_COUNT), 16'sh7fff,
                  16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_WEIGHT, 8'hff, 16'sh8000, 16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_BIAS, 8'(BIAS_COUNT), 16'sh7fff, 16'sh0000, 16'sh0000);
        send_item(mlp_pkg::OP_WRITE_BIAS, 8'hff, 16'sh8000, 16'sh0000, 16'sh0000);
        send_item(OP_RESERVED, 8'hff, 16'shffff, 16'shffff, 16'shffff);
        send_item(mlp_pkg::OP_INFER, 8'h00, 16'sh0000, 16'sh7fff, 16'sh7fff);
        send_item(mlp_pkg::OP_INFER, 8'h00, 16'sh0000, 16'sh8000, 16'sh1000);
        send_item(mlp_pkg::OP_INFER, 8'h00, 16'sh0000, 16'sh1000, 16'shf000);
    endtask

    // Cover each code on each layer, the reserved code, masked high bits
    // and every bias mask corner.
    task automatic test_activation_settings();
        apply_settings({1'b0, mlp_pkg::ACT_IDENTITY}, {1'b0, mlp_pkg::ACT_IDENTITY},
                       {1'b0, mlp_pkg::ACT_IDENTITY}, 3'b000);
        drive_traffic(10, 60);
        apply_settings({1'b1, mlp_pkg::ACT_SIGMOID}, {1'b1, mlp_pkg::ACT_SIGMOID},
                       {1'b1, mlp_pkg::ACT_SIGMOID}, 3'b111);
        drive_traffic(10, 60);
        apply_settings({1'b1, mlp_pkg::ACT_RELU}, {1'b1, mlp_pkg::ACT_RELU},
                       {1'b1, mlp_pkg::ACT_RELU}, 3'b101);
        drive_traffic(10, 60);
        apply_settings({1'b1, ACT_SPARE}, {1'b1, ACT_SPARE}, {1'b1, ACT_SPARE}, 3'b010);
        drive_traffic(10, 60);
        apply_settings({1'b0, mlp_pkg::ACT_RELU}, {1'b0, mlp_pkg::ACT_SIGMOID},
                       {1'b0, mlp_pkg::ACT_IDENTITY}, 3'b100);
        drive_traffic(10, 60);
        apply_settings({1'b0, mlp_pkg::ACT_SIGMOID}, {1'b0, mlp_pkg::ACT_IDENTITY},
                       {1'b0, mlp_pkg::ACT_RELU}, 3'b011);
        drive_traffic(10, 60);
        apply_settings({1'b0, mlp_pkg::ACT_IDENTITY}, {1'b0, mlp_pkg::ACT_RELU},
                       {1'b0, mlp_pkg::ACT_SIGMOID}, 3'b110);
        drive_traffic(10, 60);
        apply_settings({1'b0, ACT_SPARE}, {1'b0, mlp_pkg::ACT_SIGMOID},
                       {1'b0, mlp_pkg::ACT_RELU}, 3'b001);
        drive_traffic(10, 60);
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
            apply_settings(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
            drive_traffic(40, 45);
            if (phase == 2)
            begin
                drain_results();
            end
            drive_traffic(40, 45);
        end
    endtask

    task automatic test_unthrottled_tail();
        idle_pct = 0;
        apply_settings({1'b0, mlp_pkg::ACT_SIGMOID}, {1'b0, mlp_pkg::ACT_RELU},
                       {1'b0, mlp_pkg::ACT_SIGMOID}, 3'b111);
        drive_traffic(60, 50);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = mlp_pkg::OP_WRITE_WEIGHT;
        cfg_valid     = 1'b0;
        cfg_index     = mlp_pkg::CFG_HIDDEN_ONE_ACT;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_edge_values();
        test_activation_settings();
        test_random_traffic();
        test_unthrottled_tail();
        drain_results();

        $display("Run covered %0d inferences, %0d store writes, %0d dropped writes and %0d",
                 infer_count, store_write_count, stray_write_count, reserved_count);
        $display("reserved-op items over %0d settings (%0d register writes) in %0d cycles.",
                 setting_count, reg_write_count, cycle_count);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mlp_pkg.sv
design/mlp_coef_store.sv
design/mlp_mac.sv
design/mlp_act.sv
design/mlp_forward_inference_core.sv
verif/mlp_forward_inference_core_tb.sv
